// File: design/dwdt_pkg.sv
// Package with the types, register indexes and control bits of the dual watchdog timer.
package dwdt_pkg;

    localparam int unsigned WORD_WIDTH = 32;
    localparam int unsigned REG_COUNT = 8;
    localparam int unsigned INDEX_WIDTH = $clog2(REG_COUNT);

    typedef logic [WORD_WIDTH-1:0] word_t;
    typedef logic [INDEX_WIDTH-1:0] reg_index_t;
    typedef word_t [REG_COUNT-1:0] reg_file_t;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2
    } mode_t;

    localparam reg_index_t IDX_CHIP_COUNT = 3'd0;
    localparam reg_index_t IDX_CHIP_RST   = 3'd1;
    localparam reg_index_t IDX_CHIP_IRQ   = 3'd2;
    localparam reg_index_t IDX_CHIP_CTRL  = 3'd3;
    localparam reg_index_t IDX_SYS_COUNT  = 3'd4;
    localparam reg_index_t IDX_SYS_RST    = 3'd5;
    localparam reg_index_t IDX_SYS_CTRL   = 3'd7;

    localparam int unsigned CTL_EN_IRQ   = 0;
    localparam int unsigned CTL_ACK_IRQ  = 1;
    localparam int unsigned CTL_EN_RESET = 2;

    typedef struct packed {
        word_t read_data;
        logic  irq_level;
        logic  reset_pulse;
    } step_result_t;

endpackage

// File: design/dwdt_if.sv
// Handshake interfaces for the request and response channels of the watchdog.
interface dwdt_req_if;
    import dwdt_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] mode;
    reg_index_t reg_index;
    word_t      write_data;

    modport source (output valid, output mode, output reg_index, output write_data,
                    input ready);
    modport sink (input valid, input mode, input reg_index, input write_data,
                  output ready);
endinterface

interface dwdt_rsp_if;
    import dwdt_pkg::*;

    logic  valid;
    logic  ready;
    word_t read_data;
    logic  irq_level;
    logic  reset_pulse;

    modport source (output valid, output read_data, output irq_level, output reset_pulse,
                    input ready);
    modport sink (input valid, input read_data, input irq_level, input reset_pulse,
                  output ready);
endinterface

// File: design/dwdt_step.sv
// Next-state and result logic for one watchdog transaction.
module dwdt_step
    import dwdt_pkg::*;
(
    input  reg_file_t    regs,
    input  logic         irq,
    input  logic [1:0]   mode,
    input  reg_index_t   reg_index,
    input  word_t        write_data,
    output reg_file_t    regs_next,
    output logic         irq_next,
    output step_result_t result
);

    reg_file_t regs_acc;
    logic      irq_acc;
    word_t     read_word;
    word_t     wdata;
    logic      chip_rst_fire;
    logic      sys_rst_fire;
    logic      irq_fire;

    always_comb
    begin
        regs_acc  = regs;
        irq_acc   = irq;
        read_word = '0;
        wdata     = write_data;
        unique case (mode)
            MODE_TICK:
            begin
                regs_acc[IDX_CHIP_COUNT] = regs[IDX_CHIP_COUNT] + word_t'(1);
                regs_acc[IDX_SYS_COUNT]  = regs[IDX_SYS_COUNT] + word_t'(1);
            end
            MODE_READ:
            begin
                read_word = regs[reg_index];
            end
            MODE_WRITE:
            begin
                if (reg_index == IDX_CHIP_CTRL)
                begin
                    if (write_data[CTL_ACK_IRQ])
                    begin
                        irq_acc = 1'b0;
                    end
                    wdata[CTL_ACK_IRQ] = 1'b0;
                end
                regs_acc[reg_index] = wdata;
            end
            default:
            begin
            end
        endcase
    end

    assign chip_rst_fire = regs_acc[IDX_CHIP_CTRL][CTL_EN_RESET]
                        && (regs_acc[IDX_CHIP_COUNT] >= regs_acc[IDX_CHIP_RST]);
    assign sys_rst_fire  = regs_acc[IDX_SYS_CTRL][CTL_EN_RESET]
                        && (regs_acc[IDX_SYS_COUNT] >= regs_acc[IDX_SYS_RST]);
    assign irq_fire      = regs_acc[IDX_CHIP_CTRL][CTL_EN_IRQ]
                        && !regs_acc[IDX_CHIP_CTRL][CTL_ACK_IRQ]
                        && (regs_acc[IDX_CHIP_COUNT] >= regs_acc[IDX_CHIP_IRQ]);

    always_comb
    begin
        regs_next = regs_acc;
        irq_next  = irq_acc;
        priority if (chip_rst_fire || sys_rst_fire)
        begin
            regs_next = '0;
        end
        else if (irq_fire)
        begin
            regs_next[IDX_CHIP_CTRL][CTL_ACK_IRQ] = 1'b1;
            irq_next = 1'b1;
        end
        else
        begin
        end
    end

    assign result.read_data   = read_word;
    assign result.irq_level   = irq_next;
    assign result.reset_pulse = chip_rst_fire || sys_rst_fire;

endmodule

// File: design/dual_watchdog_timer_regs_top.sv
// Top level of the register-mapped dual watchdog timer.
//
// The req channel carries one transaction per item: a counter tick, a register
// read or a register write to one of eight word registers. The rsp channel
// returns exactly one transaction per request with the read data (zero unless
// the request was a read), the interrupt level after the request and a flag
// that is set when a chip or system watchdog reset fired.
// A request is applied to the register file in the cycle it is accepted, and
// its response is valid in the following cycle. Throughput is one request per
// cycle unless the receiver stalls; the single path from the register file
// through the increment, the limit compares and the register select sets it.
// The output register frees itself in the cycle the response is taken, so a
// new request is accepted while a response is being delivered.
// When the receiver stalls, the response is held and req.ready drops until the
// response is taken.
// Reset clears all eight registers, the interrupt line and the response valid.
// A fired watchdog reset clears the registers but leaves the interrupt level.
module dual_watchdog_timer_regs_top
    import dwdt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    dwdt_req_if.sink   req,
    dwdt_rsp_if.source rsp
);

    reg_file_t    regs_reg;
    reg_file_t    regs_next;
    logic         irq_reg;
    logic         irq_next;
    logic         rsp_valid_reg;
    step_result_t rsp_data_reg;
    step_result_t step_result;
    logic         accept;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    dwdt_step u_step (
        .regs       (regs_reg),
        .irq        (irq_reg),
        .mode       (req.mode),
        .reg_index  (req.reg_index),
        .write_data (req.write_data),
        .regs_next  (regs_next),
        .irq_next   (irq_next),
        .result     (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg      <= '0;
            irq_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                regs_reg      <= regs_next;
                irq_reg       <= irq_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_data_reg <= step_result;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.read_data   = rsp_data_reg.read_data;
    assign rsp.irq_level   = rsp_data_reg.irq_level;
    assign rsp.reset_pulse = rsp_data_reg.reset_pulse;

    // A fired watchdog reset leaves both counters at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && step_result.reset_pulse) |=>
            (regs_reg[IDX_CHIP_COUNT] == '0 && regs_reg[IDX_SYS_COUNT] == '0))
    else $error("counters not cleared after watchdog reset");

    // The pending bit is only ever set together with the interrupt line.
    assert property (@(posedge clk) disable iff (!rst_n)
        regs_reg[IDX_CHIP_CTRL][CTL_ACK_IRQ] |-> irq_reg)
    else $error("interrupt pending without interrupt line");

    // The pending bit implies the interrupt is enabled.
    assert property (@(posedge clk) disable iff (!rst_n)
        regs_reg[IDX_CHIP_CTRL][CTL_ACK_IRQ] |-> regs_reg[IDX_CHIP_CTRL][CTL_EN_IRQ])
    else $error("interrupt pending while disabled");

    // Every accepted request produces a response in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
    else $error("response missing after accepted request");

endmodule
